FILE: rtl/core/mclw_pkg.sv
// ----------------------------------------------------------------------------
// mclw_pkg
// Shared types and constants of the comm-loss watchdog bank.
// ----------------------------------------------------------------------------
package mclw_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int TIMER_CAP    = 65535;
    localparam int CH_W         = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // field widths
    localparam int FUNC_W    = 2;
    localparam int CHANNEL_W = 3;
    localparam int SRC_W     = 8;
    localparam int TMO_W     = 16;
    localparam int CODE_W    = 2;
    localparam int TICK_W    = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DISABLE_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNKNOWN_SRC   = 2'd2;

    localparam logic [TICK_W-1:0] TICK_RESET = 10'd10;

    // event kind reported on expiry
    localparam logic [CODE_W-1:0] EVT_COMM_LOSS = 2'd0;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_INSTALL = 2'd1,
        FUNC_FEED    = 2'd2,
        FUNC_TRIGGER = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_TRIG,
        ST_FLUSH
    } t_state;

    // write side of the channel bank
    typedef struct packed {
        logic             inst_we;
        logic             en_we;
        logic             en_val;
        logic             elap_we;
        logic [TMO_W-1:0] elap_val;
        logic             tmo_we;
        logic [TMO_W-1:0] tmo_val;
        logic             src_we;
        logic [SRC_W-1:0] src_val;
    } t_bank_wr;

    // read side of the channel bank
    typedef struct packed {
        logic             installed;
        logic             enabled;
        logic [TMO_W-1:0] elapsed;
        logic [TMO_W-1:0] timeout;
        logic [SRC_W-1:0] source;
    } t_bank_rd;

    // shared unit results
    typedef struct packed {
        logic [TMO_W-1:0] sat_elapsed;
        logic             expire;
        logic             armed;
        logic             match;
    } t_unit_res;

endpackage

FILE: rtl/core/multi_channel_comm_loss_watchdog.sv
// ----------------------------------------------------------------------------
// multi_channel_comm_loss_watchdog
// Bank of comm-loss watchdogs walked by a sequencer over one timer unit.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: a transaction is taken on a clock edge with i_start high
//    and o_busy low. i_func selects tick, install, feed or trigger.
//  - Install and feed complete on the accepting edge (no result);
//    o_busy stays low.
//  - A tick walks every channel, one per cycle through the shared timer unit,
//    then passes through the flush step. Each expiry event is held until the
//    next expiry is found or the flush step is reached, and then leaves
//    through the output register, so the final one can carry o_last.
//  - A trigger walks channels until the first installed source match or the
//    last channel (skipped for the unknown id), then the flush step, and
//    always emits exactly one event with o_last set.
//  - Results: o_valid strobes for one cycle per event; the receiver cannot
//    stall, so none is held.
//  - Configuration: separate write channel, o_cfg_ready always high; write
//    only while the block is idle.
//  - Reset (synchronous, active low): all channels uninstalled and disabled,
//    registers to their defaults, no result pending.
// ----------------------------------------------------------------------------
module multi_channel_comm_loss_watchdog (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // command channel
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [mclw_pkg::FUNC_W-1:0]     i_func,
    input  logic [mclw_pkg::CHANNEL_W-1:0]  i_channel,
    input  logic [mclw_pkg::SRC_W-1:0]      i_source_id,
    input  logic [mclw_pkg::TMO_W-1:0]      i_timeout_ms,
    input  logic [mclw_pkg::CODE_W-1:0]     i_trigger_code,
    // result strobe
    output logic                            o_valid,
    output logic [mclw_pkg::CODE_W-1:0]     o_event_kind,
    output logic [mclw_pkg::SRC_W-1:0]      o_event_source,
    output logic                            o_last,
    // configuration write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mclw_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mclw_pkg::CFG_DAT_W-1:0]  i_cfg_data
);

    localparam int ADDR_EXT_W = (mclw_pkg::CH_W > mclw_pkg::CHANNEL_W)
                              ? mclw_pkg::CH_W : mclw_pkg::CHANNEL_W;

    // configuration registers
    logic [mclw_pkg::TICK_W-1:0] r_tick_interval;
    logic [mclw_pkg::TMO_W-1:0]  r_disable_thr;
    logic [mclw_pkg::SRC_W-1:0]  r_unknown_src;

    // sequencer
    mclw_pkg::t_state            r_state, n_state;
    logic [mclw_pkg::CH_W-1:0]   r_idx, n_idx;
    logic [mclw_pkg::SRC_W-1:0]  r_key, n_key;

    // one-deep hold of the most recent event, so the final one gets o_last
    logic                        r_pend_valid, n_pend_valid;
    logic [mclw_pkg::CODE_W-1:0] r_pend_kind, n_pend_kind;
    logic [mclw_pkg::SRC_W-1:0]  r_pend_src, n_pend_src;

    // output register
    logic                        r_out_valid, n_out_valid;
    logic [mclw_pkg::CODE_W-1:0] r_out_kind, n_out_kind;
    logic [mclw_pkg::SRC_W-1:0]  r_out_src, n_out_src;
    logic                        r_out_last, n_out_last;

    logic                        accept;
    mclw_pkg::t_func             func;
    logic [ADDR_EXT_W-1:0]       ch_ext;
    logic                        ch_in_range;
    logic [mclw_pkg::CH_W-1:0]   addr;
    logic                        idx_last;
    logic                        tick_live;
    logic                        trig_hit;

    mclw_pkg::t_bank_wr          bank_wr;
    mclw_pkg::t_bank_rd          bank_rd;
    mclw_pkg::t_unit_res         unit_res;

    assign accept      = i_start && (r_state == mclw_pkg::ST_IDLE);
    assign func        = mclw_pkg::t_func'(i_func);
    assign ch_ext      = ADDR_EXT_W'(i_channel);
    assign ch_in_range = (32'(i_channel) < mclw_pkg::NUM_CHANNELS);
    // idle: address the commanded channel; walking: the scan index
    assign addr        = (r_state == mclw_pkg::ST_IDLE) ? ch_ext[mclw_pkg::CH_W-1:0] : r_idx;
    assign idx_last    = (r_idx == mclw_pkg::CH_W'(mclw_pkg::NUM_CHANNELS - 1));
    assign tick_live   = bank_rd.installed && bank_rd.enabled && unit_res.armed;
    assign trig_hit    = bank_rd.installed && unit_res.match;

    mclw_bank u_bank (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_addr  (addr),
        .i_wr    (bank_wr),
        .o_rd    (bank_rd)
    );

    mclw_unit u_unit (
        .i_elapsed       (bank_rd.elapsed),
        .i_tick_interval (r_tick_interval),
        .i_timeout       (bank_rd.timeout),
        .i_threshold     (r_disable_thr),
        .i_source        (bank_rd.source),
        .i_key           (r_key),
        .o_res           (unit_res)
    );

    // configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_interval <= mclw_pkg::TICK_RESET;
            r_disable_thr   <= '0;
            r_unknown_src   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                mclw_pkg::CFG_TICK_INTERVAL: begin
                    r_tick_interval <= i_cfg_data[mclw_pkg::TICK_W-1:0];
                end
                mclw_pkg::CFG_DISABLE_THR: begin
                    r_disable_thr <= i_cfg_data[mclw_pkg::TMO_W-1:0];
                end
                mclw_pkg::CFG_UNKNOWN_SRC: begin
                    r_unknown_src <= i_cfg_data[mclw_pkg::SRC_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            mclw_pkg::ST_IDLE: begin
                if (accept) begin
                    unique case (func)
                        mclw_pkg::FUNC_TICK: begin
                            n_state = mclw_pkg::ST_TICK;
                        end
                        mclw_pkg::FUNC_TRIGGER: begin
                            n_state = (i_source_id != r_unknown_src)
                                    ? mclw_pkg::ST_TRIG : mclw_pkg::ST_FLUSH;
                        end
                        default: begin
                            n_state = mclw_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            mclw_pkg::ST_TICK: begin
                if (idx_last) begin
                    n_state = mclw_pkg::ST_FLUSH;
                end
            end
            mclw_pkg::ST_TRIG: begin
                if (trig_hit || idx_last) begin
                    n_state = mclw_pkg::ST_FLUSH;
                end
            end
            mclw_pkg::ST_FLUSH: begin
                n_state = mclw_pkg::ST_IDLE;
            end
            default: begin
                n_state = mclw_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath control
    always_comb begin
        bank_wr      = '0;
        n_idx        = r_idx;
        n_key        = r_key;
        n_pend_valid = r_pend_valid;
        n_pend_kind  = r_pend_kind;
        n_pend_src   = r_pend_src;
        n_out_valid  = 1'b0;
        n_out_kind   = r_out_kind;
        n_out_src    = r_out_src;
        n_out_last   = r_out_last;
        unique case (r_state)
            mclw_pkg::ST_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    n_key = i_source_id;
                    unique case (func)
                        mclw_pkg::FUNC_TICK: begin
                            n_pend_valid = 1'b0;
                        end
                        mclw_pkg::FUNC_INSTALL: begin
                            if (ch_in_range) begin
                                bank_wr.inst_we  = 1'b1;
                                bank_wr.en_we    = 1'b1;
                                bank_wr.en_val   = 1'b0;
                                bank_wr.elap_we  = 1'b1;
                                bank_wr.elap_val = '0;
                                bank_wr.tmo_we   = 1'b1;
                                bank_wr.tmo_val  = i_timeout_ms;
                                bank_wr.src_we   = 1'b1;
                                bank_wr.src_val  = i_source_id;
                            end
                        end
                        mclw_pkg::FUNC_FEED: begin
                            if (ch_in_range && bank_rd.installed) begin
                                bank_wr.en_we    = 1'b1;
                                bank_wr.en_val   = 1'b1;
                                bank_wr.elap_we  = 1'b1;
                                bank_wr.elap_val = '0;
                                bank_wr.tmo_we   = 1'b1;
                                bank_wr.tmo_val  = i_timeout_ms;
                            end
                        end
                        mclw_pkg::FUNC_TRIGGER: begin
                            n_pend_valid = 1'b1;
                            n_pend_kind  = i_trigger_code;
                            n_pend_src   = i_source_id;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            mclw_pkg::ST_TICK: begin
                n_idx = r_idx + 1'b1;
                if (tick_live) begin
                    bank_wr.elap_we  = 1'b1;
                    bank_wr.elap_val = unit_res.sat_elapsed;
                    if (unit_res.expire) begin
                        bank_wr.en_we  = 1'b1;
                        bank_wr.en_val = 1'b0;
                        // earlier expiry is not the final one: release it now
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_kind  = r_pend_kind;
                            n_out_src   = r_pend_src;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_kind  = mclw_pkg::EVT_COMM_LOSS;
                        n_pend_src   = bank_rd.source;
                    end
                end
            end
            mclw_pkg::ST_TRIG: begin
                n_idx = r_idx + 1'b1;
                if (trig_hit) begin
                    bank_wr.en_we  = 1'b1;
                    bank_wr.en_val = 1'b0;
                end
            end
            mclw_pkg::ST_FLUSH: begin
                if (r_pend_valid) begin
                    n_out_valid  = 1'b1;
                    n_out_kind   = r_pend_kind;
                    n_out_src    = r_pend_src;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= mclw_pkg::ST_IDLE;
            r_idx        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key       <= n_key;
        r_pend_kind <= n_pend_kind;
        r_pend_src  <= n_pend_src;
        r_out_kind  <= n_out_kind;
        r_out_src   <= n_out_src;
        r_out_last  <= n_out_last;
    end

    assign o_busy         = (r_state != mclw_pkg::ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_event_kind   = r_out_kind;
    assign o_event_source = r_out_src;
    assign o_last         = r_out_last;

    // the final event of a transaction is never followed at once by another
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("event directly after a final event");

    // an event without o_last only appears while a tick walk is still open
    a_nonlast_in_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state == mclw_pkg::ST_TICK || r_state == mclw_pkg::ST_FLUSH))
        else $error("non-final event outside a tick walk");

    // busy ends only through the flush step
    a_busy_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(o_busy) && $past(i_rst_n)) |-> ($past(r_state) == mclw_pkg::ST_FLUSH))
        else $error("busy dropped without flushing");

endmodule

FILE: rtl/core/mclw_unit.sv
// ----------------------------------------------------------------------------
// mclw_unit
// Shared timer unit: saturating add, expiry and threshold compares, id match.
// ----------------------------------------------------------------------------
module mclw_unit (
    input  logic [mclw_pkg::TMO_W-1:0]  i_elapsed,
    input  logic [mclw_pkg::TICK_W-1:0] i_tick_interval,
    input  logic [mclw_pkg::TMO_W-1:0]  i_timeout,
    input  logic [mclw_pkg::TMO_W-1:0]  i_threshold,
    input  logic [mclw_pkg::SRC_W-1:0]  i_source,
    input  logic [mclw_pkg::SRC_W-1:0]  i_key,
    output mclw_pkg::t_unit_res         o_res
);

    logic [mclw_pkg::TMO_W:0]   sum;
    logic [mclw_pkg::TMO_W-1:0] sat;

    assign sum = {1'b0, i_elapsed} + (mclw_pkg::TMO_W+1)'(i_tick_interval);
    assign sat = (sum > (mclw_pkg::TMO_W+1)'(mclw_pkg::TIMER_CAP))
               ? mclw_pkg::TMO_W'(mclw_pkg::TIMER_CAP) : sum[mclw_pkg::TMO_W-1:0];

    always_comb begin
        o_res.sat_elapsed = sat;
        o_res.expire      = (sat >= i_timeout);
        o_res.armed       = (i_timeout > i_threshold);
        o_res.match       = (i_source == i_key);
    end

endmodule

FILE: rtl/core/mclw_bank.sv
// ----------------------------------------------------------------------------
// mclw_bank
// Per-channel watchdog state, one shared read/write address per cycle.
// ----------------------------------------------------------------------------
module mclw_bank (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [mclw_pkg::CH_W-1:0]   i_addr,
    input  mclw_pkg::t_bank_wr          i_wr,
    output mclw_pkg::t_bank_rd          o_rd
);

    logic [mclw_pkg::NUM_CHANNELS-1:0] r_installed;
    logic [mclw_pkg::NUM_CHANNELS-1:0] r_enabled;
    logic [mclw_pkg::TMO_W-1:0]        r_elapsed [mclw_pkg::NUM_CHANNELS];
    logic [mclw_pkg::TMO_W-1:0]        r_timeout [mclw_pkg::NUM_CHANNELS];
    logic [mclw_pkg::SRC_W-1:0]        r_source  [mclw_pkg::NUM_CHANNELS];

    // flags reset; timer, timeout and id are only read once installed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_installed <= '0;
            r_enabled   <= '0;
        end else begin
            if (i_wr.inst_we) begin
                r_installed[i_addr] <= 1'b1;
            end
            if (i_wr.en_we) begin
                r_enabled[i_addr] <= i_wr.en_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.elap_we) begin
            r_elapsed[i_addr] <= i_wr.elap_val;
        end
        if (i_wr.tmo_we) begin
            r_timeout[i_addr] <= i_wr.tmo_val;
        end
        if (i_wr.src_we) begin
            r_source[i_addr] <= i_wr.src_val;
        end
    end

    always_comb begin
        o_rd.installed = r_installed[i_addr];
        o_rd.enabled   = r_enabled[i_addr];
        o_rd.elapsed   = r_elapsed[i_addr];
        o_rd.timeout   = r_timeout[i_addr];
        o_rd.source    = r_source[i_addr];
    end

endmodule
